// ----- rtl/varispeed_linear_resampler_assert.svh -----
// Assertion macros for the varispeed linear resampler.
// Included by the top level; no other dependencies.
`ifndef VARISPEED_LINEAR_RESAMPLER_ASSERT_SVH
`define VARISPEED_LINEAR_RESAMPLER_ASSERT_SVH
`ifndef SYNTH
`define VLR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vlr assertion failed");
`define VLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vlr assertion failed");
`else
`define VLR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define VLR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/vlr_pkg.sv -----
// Shared constants and types for the varispeed linear resampler.
// No dependencies.
`default_nettype none
package vlr_pkg;

   localparam int ADDR_BITS   = 16;
   localparam int STORE_DEPTH = 1 << ADDR_BITS;
   localparam int SAMPLE_BITS = 24;
   localparam int FRAME_BITS  = 12;
   localparam int MAX_BLOCK   = 1 << FRAME_BITS;
   localparam int SPEED_BITS  = 9;
   localparam int GAIN_BITS   = 16;
   localparam int OFFSET_BITS = 15;
   localparam int WEIGHT_BITS = 8;
   localparam int OP_BITS     = 2;

   localparam logic [OP_BITS-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_RENDER = 2'd1;
   localparam logic [OP_BITS-1:0] OP_SEEK   = 2'd2;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN  = 1'd1;

   localparam logic signed [SPEED_BITS-1:0] SPEED_RESET = 9'sd100;
   localparam logic [GAIN_BITS-1:0]         GAIN_RESET  = 16'd16384;

   // shared multiplier operand widths
   localparam int MUL_A_BITS = 34;
   localparam int MUL_B_BITS = 25;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

   // divide by 100: floor reciprocal plus one correction step
   localparam int DIV100_SHIFT = 21;
   localparam int HUNDRED      = 100;
   localparam int RECIP100_BITS = 15;
   localparam logic [RECIP100_BITS-1:0] RECIP_100 =
      RECIP100_BITS'((1 << DIV100_SHIFT) / HUNDRED);
   localparam int Q100_BITS = 14;

   // divide by 25 after the shift by 16 (100 * 16384 = 25 << 16)
   localparam int GAIN_SHIFT  = 16;
   localparam int DIV25_SHIFT = 28;
   localparam int TWENTYFIVE  = 25;
   localparam int RECIP25_BITS = 24;
   localparam logic [RECIP25_BITS-1:0] RECIP_25 =
      RECIP25_BITS'((1 << DIV25_SHIFT) / TWENTYFIVE);
   localparam int Q25_BITS  = SAMPLE_BITS - 1;
   localparam logic [31:0] SAT_LIMIT = 32'(TWENTYFIVE * (1 << (SAMPLE_BITS - 1)));

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic                         start;
      logic signed [MUL_A_BITS-1:0] a;
      logic signed [MUL_B_BITS-1:0] b;
   } mul_req_type;

endpackage
`default_nettype wire

// ----- rtl/vlr_req_if.sv -----
// Request channel: load, render and seek words.
// Depends on vlr_pkg.
`default_nettype none
interface vlr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [vlr_pkg::OP_BITS-1:0]            operation;
   logic [vlr_pkg::ADDR_BITS-1:0]          address;
   logic signed [vlr_pkg::SAMPLE_BITS-1:0] left_in;
   logic signed [vlr_pkg::SAMPLE_BITS-1:0] right_in;
   logic                                   block_start;

   modport source (output valid, operation, address, left_in, right_in, block_start,
                   input ready);
   modport sink (input valid, operation, address, left_in, right_in, block_start,
                 output ready);
endinterface
`default_nettype wire

// ----- rtl/vlr_rsp_if.sv -----
// Response channel: one rendered stereo frame per word.
// Depends on vlr_pkg.
`default_nettype none
interface vlr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [vlr_pkg::SAMPLE_BITS-1:0] left_out;
   logic signed [vlr_pkg::SAMPLE_BITS-1:0] right_out;
   logic [vlr_pkg::ADDR_BITS-1:0]          read_address;

   modport source (output valid, left_out, right_out, read_address, input ready);
   modport sink (input valid, left_out, right_out, read_address, output ready);
endinterface
`default_nettype wire

// ----- rtl/vlr_csr_if.sv -----
// Register write channel: index and data.
// Depends on vlr_pkg.
`default_nettype none
interface vlr_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [vlr_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [vlr_pkg::CSR_DATA_BITS-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/vlr_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module vlr_ram #(
   parameter int WIDTH  = 48,
   parameter int DEPTH  = 65536,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/vlr_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on vlr_pkg.
`default_nettype none
module vlr_mul (
   input  wire logic                                  clock,
   input  wire vlr_pkg::mul_req_type                  mul_req,
   output logic signed [vlr_pkg::MUL_P_BITS-1:0]      product
);

   logic signed [vlr_pkg::MUL_P_BITS-1:0] product_ff;
   logic signed [vlr_pkg::MUL_P_BITS-1:0] product_in;

   assign product_in = vlr_pkg::MUL_P_BITS'($signed(mul_req.a))
                     * vlr_pkg::MUL_P_BITS'($signed(mul_req.b));

   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule
`default_nettype wire

// ----- rtl/varispeed_linear_resampler.sv -----
// Variable-speed stereo playback with two-tap linear interpolation and gain.
// Load and seek words complete in the cycle they are taken. A render word occupies the block
// until its frame is passed to rsp: rsp valid rises in the cycle req ready returns. The
// render steps share one multiplier (8 products per frame) and the store's single read port;
// a frame still unaccepted on rsp holds the block until it leaves. Synchronous active-high
// reset clears control state, position and registers; the sample store is not cleared.
`default_nettype none
`include "varispeed_linear_resampler_assert.svh"
module varispeed_linear_resampler (
   input  wire logic clock,
   input  wire logic reset,
   vlr_req_if.sink   req_chan,
   vlr_rsp_if.source rsp_chan,
   vlr_csr_if.sink   csr_chan
);

   localparam int AW = vlr_pkg::ADDR_BITS;
   localparam int SW = vlr_pkg::SAMPLE_BITS;
   localparam int PW = vlr_pkg::MUL_P_BITS;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_PROD = 4'd1;
   localparam logic [3:0] ST_QEST = 4'd2;
   localparam logic [3:0] ST_QFIX = 4'd3;
   localparam logic [3:0] ST_RD0  = 4'd4;
   localparam logic [3:0] ST_RD1  = 4'd5;
   localparam logic [3:0] ST_CAPB = 4'd6;
   localparam logic [3:0] ST_MULR = 4'd7;
   localparam logic [3:0] ST_SUM  = 4'd8;
   localparam logic [3:0] ST_MULG = 4'd9;
   localparam logic [3:0] ST_MAG  = 4'd10;
   localparam logic [3:0] ST_MULD = 4'd11;
   localparam logic [3:0] ST_DFIX = 4'd12;
   localparam logic [3:0] ST_OUT  = 4'd13;

   logic [3:0] state_ff, state_in;
   logic signed [vlr_pkg::SPEED_BITS-1:0] speed_ff, speed_in;
   logic [vlr_pkg::GAIN_BITS-1:0] gain_ff, gain_in;
   logic [AW-1:0] base_ff, base_in;
   logic [vlr_pkg::FRAME_BITS-1:0] frame_ff, frame_in;
   logic signed [vlr_pkg::OFFSET_BITS-1:0] last_off_ff, last_off_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic neg_ff, neg_in;
   logic sat_ff, sat_in;
   logic [27:0] mag_ff, mag_in;
   logic signed [vlr_pkg::OFFSET_BITS-1:0] off_ff, off_in;
   logic signed [vlr_pkg::WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [AW-1:0] p0_ff, p0_in;
   logic [2*SW-1:0] a_pair_ff, a_pair_in;
   logic [2*SW-1:0] b_pair_ff, b_pair_in;
   logic ch_ff, ch_in;
   logic signed [vlr_pkg::MUL_A_BITS-1:0] sum_ff, sum_in;
   logic signed [SW-1:0] left_res_ff, left_res_in;
   logic signed [SW-1:0] right_res_ff, right_res_in;
   logic signed [SW-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SW-1:0] rsp_right_ff, rsp_right_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;

   logic req_fire;
   logic csr_fire;
   vlr_pkg::mul_req_type mul_req;
   logic signed [PW-1:0] product;
   logic [2*SW-1:0] rd_data;
   logic [AW-1:0] rd_addr;
   logic ram_wr_en;

   // divide by 100
   logic [20:0] prod_abs;
   logic [vlr_pkg::Q100_BITS-1:0] q100_est;
   logic [20:0] q100_ext;
   logic [20:0] rem100_raw;
   logic [7:0] rem100;
   logic [vlr_pkg::Q100_BITS-1:0] fix_q;
   logic [7:0] fix_rem;
   logic signed [vlr_pkg::OFFSET_BITS-1:0] off_val;
   logic signed [vlr_pkg::WEIGHT_BITS-1:0] weight_val;
   logic [AW-1:0] p0_calc;

   // mixing
   logic signed [SW-1:0] a_s, b_s;
   logic signed [SW:0] diff;
   logic signed [vlr_pkg::MUL_A_BITS-1:0] a_ext;
   logic signed [vlr_pkg::MUL_A_BITS-1:0] sum_val;

   // gain and divide by 25 << 16
   logic acc_neg;
   logic [47:0] acc_mag;
   logic [31:0] t_full;
   logic [vlr_pkg::Q25_BITS-1:0] q25_est;
   logic [27:0] q25_ext;
   logic [27:0] rem25_raw;
   logic [5:0] rem25;
   logic [vlr_pkg::Q25_BITS-1:0] q25_fix;
   logic [5:0] fix25_rem;
   logic [SW-1:0] q25_wide;
   logic signed [SW-1:0] res_val;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && !reset;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.left_out     = rsp_left_ff;
   assign rsp_chan.right_out    = rsp_right_ff;
   assign rsp_chan.read_address = rsp_addr_ff;

   assign ram_wr_en = req_fire && (req_chan.operation == vlr_pkg::OP_LOAD);
   assign rd_addr   = (state_ff == ST_RD1) ? (p0_ff + AW'(1)) : p0_calc;

   vlr_ram #(
      .WIDTH (2 * SW),
      .DEPTH (vlr_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_chan.address),
      .wr_data ({req_chan.left_in, req_chan.right_in}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   vlr_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (product)
   );

   // frame * speed -> offset and signed remainder
   assign prod_abs   = product[20] ? (~product[20:0] + 21'd1) : product[20:0];
   assign q100_est   = product[vlr_pkg::DIV100_SHIFT +: vlr_pkg::Q100_BITS];
   assign q100_ext   = 21'(q100_est);
   assign rem100_raw = mag_ff[20:0] - ((q100_ext << 6) + (q100_ext << 5) + (q100_ext << 2));
   assign rem100     = rem100_raw[7:0];
   assign fix_q      = (rem100 >= 8'(vlr_pkg::HUNDRED)) ? (q100_est + 1'b1) : q100_est;
   assign fix_rem    = (rem100 >= 8'(vlr_pkg::HUNDRED)) ?
                       (rem100 - 8'(vlr_pkg::HUNDRED)) : rem100;
   assign off_val    = neg_ff ? -$signed(vlr_pkg::OFFSET_BITS'(fix_q))
                              : $signed(vlr_pkg::OFFSET_BITS'(fix_q));
   assign weight_val = neg_ff ? -$signed(fix_rem) : $signed(fix_rem);
   assign p0_calc    = base_ff + {off_ff[vlr_pkg::OFFSET_BITS-1], off_ff};

   // left sits in the upper half of a stored pair
   assign a_s   = ch_ff ? a_pair_ff[SW-1:0] : a_pair_ff[2*SW-1:SW];
   assign b_s   = ch_ff ? b_pair_ff[SW-1:0] : b_pair_ff[2*SW-1:SW];
   assign diff  = {b_s[SW-1], b_s} - {a_s[SW-1], a_s};
   assign a_ext = {{(vlr_pkg::MUL_A_BITS-SW){a_s[SW-1]}}, a_s};
   assign sum_val = (a_ext <<< 6) + (a_ext <<< 5) + (a_ext <<< 2)
                  + product[vlr_pkg::MUL_A_BITS-1:0];

   assign acc_neg = product[48];
   assign acc_mag = acc_neg ? (~product[47:0] + 48'd1) : product[47:0];
   assign t_full  = acc_mag[47:vlr_pkg::GAIN_SHIFT];

   assign q25_est   = product[vlr_pkg::DIV25_SHIFT +: vlr_pkg::Q25_BITS];
   assign q25_ext   = 28'(q25_est);
   assign rem25_raw = mag_ff - ((q25_ext << 4) + (q25_ext << 3) + q25_ext);
   assign rem25     = rem25_raw[5:0];
   assign q25_fix   = (rem25 >= 6'(vlr_pkg::TWENTYFIVE)) ? (q25_est + 1'b1) : q25_est;
   assign fix25_rem = (rem25 >= 6'(vlr_pkg::TWENTYFIVE)) ?
                      (rem25 - 6'(vlr_pkg::TWENTYFIVE)) : rem25;
   assign q25_wide  = {1'b0, q25_fix};
   assign res_val   = sat_ff ? (neg_ff ? vlr_pkg::SAMPLE_MIN : vlr_pkg::SAMPLE_MAX)
                             : (neg_ff ? -$signed(q25_wide) : $signed(q25_wide));

   always_comb begin
      state_in     = state_ff;
      speed_in     = speed_ff;
      gain_in      = gain_ff;
      base_in      = base_ff;
      frame_in     = frame_ff;
      last_off_in  = last_off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      mag_in       = mag_ff;
      off_in       = off_ff;
      weight_in    = weight_ff;
      p0_in        = p0_ff;
      a_pair_in    = a_pair_ff;
      b_pair_in    = b_pair_ff;
      ch_in        = ch_ff;
      sum_in       = sum_ff;
      left_res_in  = left_res_ff;
      right_res_in = right_res_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_addr_in  = rsp_addr_ff;
      mul_req.start = 1'b0;
      mul_req.a     = '0;
      mul_req.b     = '0;

      if (csr_fire) begin
         case (csr_chan.index)
            vlr_pkg::CSR_SPEED: speed_in = csr_chan.data[vlr_pkg::SPEED_BITS-1:0];
            vlr_pkg::CSR_GAIN:  gain_in  = csr_chan.data[vlr_pkg::GAIN_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.operation)
                  vlr_pkg::OP_SEEK: begin
                     base_in     = req_chan.address;
                     last_off_in = '0;
                     frame_in    = '0;
                  end
                  vlr_pkg::OP_RENDER: begin
                     if (req_chan.block_start) begin
                        base_in  = base_ff + {last_off_ff[vlr_pkg::OFFSET_BITS-1], last_off_ff};
                        frame_in = '0;
                     end
                     state_in = ST_PROD;
                  end
                  default: ;
               endcase
            end
         end
         ST_PROD: begin
            mul_req.start = 1'b1;
            mul_req.a     = vlr_pkg::MUL_A_BITS'(frame_ff);
            mul_req.b     = vlr_pkg::MUL_B_BITS'(speed_ff);
            state_in      = ST_QEST;
         end
         ST_QEST: begin
            neg_in        = product[20];
            mag_in        = 28'(prod_abs);
            mul_req.start = 1'b1;
            mul_req.a     = vlr_pkg::MUL_A_BITS'(prod_abs);
            mul_req.b     = vlr_pkg::MUL_B_BITS'(vlr_pkg::RECIP_100);
            state_in      = ST_QFIX;
         end
         ST_QFIX: begin
            off_in      = off_val;
            weight_in   = weight_val;
            last_off_in = off_val;
            if (frame_ff != vlr_pkg::FRAME_BITS'(vlr_pkg::MAX_BLOCK - 1)) begin
               frame_in = frame_ff + 1'b1;
            end
            state_in = ST_RD0;
         end
         ST_RD0: begin
            p0_in    = p0_calc;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            a_pair_in = rd_data;
            state_in  = ST_CAPB;
         end
         ST_CAPB: begin
            b_pair_in = rd_data;
            ch_in     = 1'b0;
            state_in  = ST_MULR;
         end
         ST_MULR: begin
            mul_req.start = 1'b1;
            mul_req.a     = vlr_pkg::MUL_A_BITS'(diff);
            mul_req.b     = vlr_pkg::MUL_B_BITS'(weight_ff);
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            sum_in   = sum_val;
            state_in = ST_MULG;
         end
         ST_MULG: begin
            mul_req.start = 1'b1;
            mul_req.a     = sum_ff;
            mul_req.b     = vlr_pkg::MUL_B_BITS'(gain_ff);
            state_in      = ST_MAG;
         end
         ST_MAG: begin
            neg_in   = acc_neg;
            sat_in   = (t_full >= vlr_pkg::SAT_LIMIT);
            mag_in   = t_full[27:0];
            state_in = ST_MULD;
         end
         ST_MULD: begin
            mul_req.start = 1'b1;
            mul_req.a     = vlr_pkg::MUL_A_BITS'(mag_ff);
            mul_req.b     = vlr_pkg::MUL_B_BITS'(vlr_pkg::RECIP_25);
            state_in      = ST_DFIX;
         end
         ST_DFIX: begin
            if (!ch_ff) begin
               left_res_in = res_val;
               ch_in       = 1'b1;
               state_in    = ST_MULR;
            end else begin
               right_res_in = res_val;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = left_res_ff;
               rsp_right_in = right_res_ff;
               rsp_addr_in  = p0_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         speed_ff     <= vlr_pkg::SPEED_RESET;
         gain_ff      <= vlr_pkg::GAIN_RESET;
         base_ff      <= '0;
         frame_ff     <= '0;
         last_off_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         speed_ff     <= speed_in;
         gain_ff      <= gain_in;
         base_ff      <= base_in;
         frame_ff     <= frame_in;
         last_off_ff  <= last_off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      sat_ff       <= sat_in;
      mag_ff       <= mag_in;
      off_ff       <= off_in;
      weight_ff    <= weight_in;
      p0_ff        <= p0_in;
      a_pair_ff    <= a_pair_in;
      b_pair_ff    <= b_pair_in;
      ch_ff        <= ch_in;
      sum_ff       <= sum_in;
      left_res_ff  <= left_res_in;
      right_res_ff <= right_res_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   `VLR_ASSERT_NEXT(a_render_starts, clock, reset,
      req_fire && req_chan.operation == vlr_pkg::OP_RENDER, state_ff == ST_PROD)
   `VLR_ASSERT_IMPLY(a_rsp_from_out, clock, reset,
      rsp_chan.valid && !$past(rsp_chan.valid), $past(state_ff) == ST_OUT)
   `VLR_ASSERT_IMPLY(a_rem100_fixed, clock, reset,
      state_ff == ST_QFIX, fix_rem < 8'(vlr_pkg::HUNDRED))
   `VLR_ASSERT_IMPLY(a_rem25_fixed, clock, reset,
      state_ff == ST_DFIX, fix25_rem < 6'(vlr_pkg::TWENTYFIVE))

endmodule
`default_nettype wire
